// ===== rtl/core/qau_pkg.sv =====
// Shared constants, operation codes and pipeline types for the quaternion arithmetic core.
package qau_pkg;

  localparam int unsigned DW        = 32;
  localparam int unsigned WW        = 44;
  localparam int unsigned SSQ_W     = 65;
  localparam int unsigned ISQ_STEPS = 32;
  localparam int unsigned DIV_STEPS = 32;

  localparam logic [3:0] OP_ADD   = 4'd0;
  localparam logic [3:0] OP_SUB   = 4'd1;
  localparam logic [3:0] OP_PROD  = 4'd2;
  localparam logic [3:0] OP_SCALE = 4'd3;
  localparam logic [3:0] OP_CONJ  = 4'd4;
  localparam logic [3:0] OP_INV   = 4'd5;
  localparam logic [3:0] OP_NORMZ = 4'd6;
  localparam logic [3:0] OP_RATE  = 4'd7;
  localparam logic [3:0] OP_NORM  = 4'd8;

  // Hamilton product: component c, term t uses left[HAM_L] * right[HAM_R]
  localparam logic [1:0] HAM_L [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd0, 2'd3, 2'd1, 2'd2}
  };
  localparam logic [1:0] HAM_R [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd2, 2'd1}
  };
  localparam logic [3:0] HAM_NEG [4] = '{4'b1110, 4'b1000, 4'b1000, 4'b1000};

  typedef struct packed {
    logic [3:0]            op;
    logic [3:0][WW-1:0]    wide;
    logic [3:0][DW-1:0]    mag;
    logic [3:0]            neg;
    logic [SSQ_W-1:0]      ssq;
  } isq_t;

  typedef struct packed {
    logic [3:0]            op;
    logic [3:0][WW-1:0]    wide;
    logic [3:0]            neg;
    logic [3:0]            bigq;
    logic                  zdiv;
    logic [SSQ_W-1:0]      dvs;
  } div_t;

endpackage

// ===== rtl/core/quaternion_arith_unit_core.sv =====
// Quaternion arithmetic core: sum, product, scale, conjugate, inverse, normalise, rate, norm.
// Accepts one item per cycle while the skid entry is empty.
// Depth is set by the 32-step square-root chain that feeds the 32-step restoring dividers.
// Output register plus skid entry keep the input open while one result waits.
// Synchronous active-low reset clears all valid bits; payload registers are not reset.
module quaternion_arith_unit_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // a_s, a_x, a_y, a_z, b_s, b_x, b_y, b_z, scale_factor
  input  logic [3:0]   in_tuser,   // operation
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // r_s, r_x, r_y, r_z
  output logic [1:0]   out_tuser   // overflow, zero_divisor
);
  import qau_pkg::*;

  logic en;
  logic skid_vld_r;

  assign en        = !skid_vld_r;
  assign in_tready = en;

  // stage 0: input register
  logic                  vld0_r;
  logic [3:0]            op0_r;
  logic signed [DW-1:0]  a0_r [4];
  logic signed [DW-1:0]  b0_r [4];
  logic signed [DW-1:0]  k0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op0_r <= in_tuser;
      for (int i = 0; i < 4; i++) begin
        a0_r[i] <= in_tdata[32*i +: 32];
        b0_r[i] <= in_tdata[128 + 32*i +: 32];
      end
      k0_r <= in_tdata[256 +: 32];
    end
  end

  // stage 1: multipliers
  logic signed [DW-1:0]  mx [4][4];
  logic signed [DW-1:0]  my [4][4];
  logic                  pneg [4][4];
  logic signed [63:0]    prod1_nxt [4][4];
  logic [62:0]           sq1_nxt [4];
  logic signed [WW-1:0]  simp1_nxt [4];
  logic [DW-1:0]         mag1_nxt [4];
  logic [3:0]            neg1_nxt;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int t = 0; t < 4; t++) begin
        if (op0_r == OP_SCALE) begin
          mx[c][t] = (t == 0) ? a0_r[c] : '0;
          my[c][t] = k0_r;
        end else if (op0_r == OP_RATE) begin
          mx[c][t] = (HAM_L[c][t] == 2'd0) ? '0 : b0_r[HAM_L[c][t]];
          my[c][t] = a0_r[HAM_R[c][t]];
        end else begin
          mx[c][t] = a0_r[HAM_L[c][t]];
          my[c][t] = b0_r[HAM_R[c][t]];
        end
        pneg[c][t] = HAM_NEG[c][t] && (op0_r != OP_SCALE);
      end
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_mul
    for (genvar t = 0; t < 4; t++) begin : g_term
      logic signed [63:0] p;
      assign p = 64'(mx[c][t]) * 64'(my[c][t]);
      assign prod1_nxt[c][t] = pneg[c][t] ? -p : p;
    end
    logic signed [63:0] sq;
    assign sq = 64'(a0_r[c]) * 64'(a0_r[c]);
    assign sq1_nxt[c] = sq[62:0];
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      case (op0_r)
        OP_ADD:  simp1_nxt[c] = 44'(a0_r[c]) + 44'(b0_r[c]);
        OP_SUB:  simp1_nxt[c] = 44'(a0_r[c]) - 44'(b0_r[c]);
        OP_CONJ: simp1_nxt[c] = (c == 0) ? 44'(a0_r[c]) : -44'(a0_r[c]);
        default: simp1_nxt[c] = '0;
      endcase
      mag1_nxt[c] = a0_r[c][31] ? (~a0_r[c] + 32'd1) : a0_r[c];
      if (op0_r == OP_INV && c != 0) begin
        neg1_nxt[c] = !a0_r[c][31] && (a0_r[c] != '0);
      end else begin
        neg1_nxt[c] = a0_r[c][31];
      end
    end
  end

  logic                  vld1_r, vld2_r, vld3_r;
  logic [3:0]            op1_r, op2_r, op3_r;
  logic signed [63:0]    prod1_r [4][4];
  logic [62:0]           sq1_r [4];
  logic signed [WW-1:0]  simp1_r [4], simp2_r [4], simp3_r [4];
  logic [DW-1:0]         mag1_r [4], mag2_r [4], mag3_r [4];
  logic [3:0]            neg1_r, neg2_r, neg3_r;

  // stage 2: pair sums
  logic signed [64:0]    ps2_nxt [4][2];
  logic [63:0]           sqp2_nxt [2];
  logic signed [64:0]    ps2_r [4][2];
  logic [63:0]           sqp2_r [2];

  // stage 3: full sums
  logic signed [65:0]    sum3_nxt [4];
  logic [SSQ_W-1:0]      ssq3_nxt;
  logic signed [65:0]    sum3_r [4];
  logic [SSQ_W-1:0]      ssq3_r;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int h = 0; h < 2; h++) begin
        ps2_nxt[c][h] = 65'(prod1_r[c][2*h]) + 65'(prod1_r[c][2*h+1]);
      end
      sum3_nxt[c] = 66'(ps2_r[c][0]) + 66'(ps2_r[c][1]);
    end
    for (int h = 0; h < 2; h++) begin
      sqp2_nxt[h] = 64'(sq1_r[2*h]) + 64'(sq1_r[2*h+1]);
    end
    ssq3_nxt = 65'(sqp2_r[0]) + 65'(sqp2_r[1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld0_r;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= op0_r;
      prod1_r <= prod1_nxt;
      sq1_r   <= sq1_nxt;
      simp1_r <= simp1_nxt;
      mag1_r  <= mag1_nxt;
      neg1_r  <= neg1_nxt;
      op2_r   <= op1_r;
      ps2_r   <= ps2_nxt;
      sqp2_r  <= sqp2_nxt;
      simp2_r <= simp1_r;
      mag2_r  <= mag1_r;
      neg2_r  <= neg1_r;
      op3_r   <= op2_r;
      sum3_r  <= sum3_nxt;
      ssq3_r  <= ssq3_nxt;
      simp3_r <= simp2_r;
      mag3_r  <= mag2_r;
      neg3_r  <= neg2_r;
    end
  end

  // stage 4: rounding of products, result select
  isq_t isq0_nxt;

  always_comb begin
    logic signed [65:0] rnd;
    logic signed [65:0] sh;
    isq0_nxt.op  = op3_r;
    isq0_nxt.neg = neg3_r;
    isq0_nxt.ssq = ssq3_r;
    for (int c = 0; c < 4; c++) begin
      if (op3_r == OP_RATE) begin
        rnd = sum3_r[c] + 66'sd16777216;
        sh  = rnd >>> 25;
      end else begin
        rnd = sum3_r[c] + 66'sd8388608;
        sh  = rnd >>> 24;
      end
      case (op3_r)
        OP_PROD, OP_SCALE, OP_RATE: isq0_nxt.wide[c] = sh[WW-1:0];
        default:                    isq0_nxt.wide[c] = simp3_r[c];
      endcase
      isq0_nxt.mag[c] = mag3_r[c];
    end
  end

  // square root, two radicand bits per stage
  isq_t                  isq_r   [ISQ_STEPS+1];
  logic [DW-1:0]         sqq_r   [ISQ_STEPS+1];
  logic [DW:0]           sqr_r   [ISQ_STEPS+1];
  logic [ISQ_STEPS:0]    isq_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isq_vld_r[0] <= 1'b0;
    end else if (en) begin
      isq_vld_r[0] <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      isq_r[0] <= isq0_nxt;
      sqq_r[0] <= '0;
      sqr_r[0] <= '0;
    end
  end

  for (genvar j = 0; j < ISQ_STEPS; j++) begin : g_isq
    localparam int unsigned SH = 2 * (ISQ_STEPS - 1 - j);
    logic [DW+2:0] cur;
    logic [DW+1:0] trial;
    logic          ge;

    assign cur   = {sqr_r[j], isq_r[j].ssq[SH +: 2]};
    assign trial = {sqq_r[j], 2'b01};
    assign ge    = cur >= {1'b0, trial};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        isq_vld_r[j+1] <= 1'b0;
      end else if (en) begin
        isq_vld_r[j+1] <= isq_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        isq_r[j+1] <= isq_r[j];
        sqq_r[j+1] <= {sqq_r[j][DW-2:0], ge};
        sqr_r[j+1] <= ge ? 33'(cur - {1'b0, trial}) : cur[DW:0];
      end
    end
  end

  // norm rounding and divider set-up
  isq_t                  isl;
  logic [DW:0]           norm;
  div_t                  div0_nxt;
  logic [63:0]           dr0_nxt [4];
  logic [DW-1:0]         df0_nxt [4];

  assign isl = isq_r[ISQ_STEPS];

  always_comb begin
    logic [47:0] msh;
    if (isl.ssq[SSQ_W-1]) begin
      norm = {1'b1, 32'h0};
    end else begin
      norm = {1'b0, sqq_r[ISQ_STEPS]} + 33'(sqr_r[ISQ_STEPS] > {1'b0, sqq_r[ISQ_STEPS]});
    end
    div0_nxt.op   = isl.op;
    div0_nxt.neg  = isl.neg;
    div0_nxt.zdiv = (isl.op == OP_INV || isl.op == OP_NORMZ) && (isl.ssq == '0);
    div0_nxt.dvs  = (isl.op == OP_INV) ? isl.ssq : 65'(norm);
    for (int c = 0; c < 4; c++) begin
      msh = {isl.mag[c], 16'h0};
      if (isl.op == OP_NORM) begin
        div0_nxt.wide[c] = (c == 0) ? 44'(norm) : '0;
      end else begin
        div0_nxt.wide[c] = isl.wide[c];
      end
      div0_nxt.bigq[c] = (isl.op == OP_INV) && (65'(msh) >= isl.ssq);
      if (isl.op == OP_INV) begin
        dr0_nxt[c] = 64'(msh);
        df0_nxt[c] = '0;
      end else begin
        dr0_nxt[c] = 64'(isl.mag[c][DW-1:8]);
        df0_nxt[c] = {isl.mag[c][7:0], 24'h0};
      end
    end
  end

  // restoring dividers, one quotient bit per stage, four lanes
  div_t                  div_r [DIV_STEPS+1];
  logic [63:0]           dvr_r [DIV_STEPS+1][4];
  logic [DW-1:0]         dvf_r [DIV_STEPS+1][4];
  logic [DW-1:0]         dvq_r [DIV_STEPS+1][4];
  logic [DIV_STEPS:0]    div_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_vld_r[0] <= 1'b0;
    end else if (en) begin
      div_vld_r[0] <= isq_vld_r[ISQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      div_r[0] <= div0_nxt;
      for (int c = 0; c < 4; c++) begin
        dvr_r[0][c] <= dr0_nxt[c];
        dvf_r[0][c] <= df0_nxt[c];
        dvq_r[0][c] <= '0;
      end
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_vld_r[j+1] <= 1'b0;
      end else if (en) begin
        div_vld_r[j+1] <= div_vld_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_r[j+1] <= div_r[j];
      end
    end

    for (genvar c = 0; c < 4; c++) begin : g_lane
      logic [64:0] t;
      logic        ge;

      assign t  = {dvr_r[j][c], dvf_r[j][c][DW-1]};
      assign ge = t >= div_r[j].dvs;

      always_ff @(posedge clk) begin
        if (en) begin
          dvr_r[j+1][c] <= ge ? 64'(t - div_r[j].dvs) : t[63:0];
          dvq_r[j+1][c] <= {dvq_r[j][c][DW-2:0], ge};
          dvf_r[j+1][c] <= {dvf_r[j][c][DW-2:0], 1'b0};
        end
      end
    end
  end

  // final rounding and sign of quotients
  localparam logic signed [WW-1:0] BIG_POS = 44'sd1099511627776;

  div_t                  dl;
  logic signed [WW-1:0]  fw_nxt [4];
  logic                  fvld_r;
  logic                  fzd_r;
  logic signed [WW-1:0]  fw_r [4];

  assign dl = div_r[DIV_STEPS];

  always_comb begin
    logic [DW:0] q33;
    for (int c = 0; c < 4; c++) begin
      q33 = {1'b0, dvq_r[DIV_STEPS][c]}
          + 33'({dvr_r[DIV_STEPS][c], 1'b0} >= dl.dvs);
      if (dl.op == OP_INV || dl.op == OP_NORMZ) begin
        if (dl.zdiv) begin
          fw_nxt[c] = '0;
        end else if (dl.bigq[c]) begin
          fw_nxt[c] = dl.neg[c] ? -BIG_POS : BIG_POS;
        end else begin
          fw_nxt[c] = dl.neg[c] ? -$signed(44'(q33)) : $signed(44'(q33));
        end
      end else begin
        fw_nxt[c] = $signed(dl.wide[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvld_r <= 1'b0;
    end else if (en) begin
      fvld_r <= div_vld_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fw_r  <= fw_nxt;
      fzd_r <= dl.zdiv;
    end
  end

  // saturation, output register and skid entry
  logic [127:0] pipe_data;
  logic [1:0]   pipe_user;

  always_comb begin
    logic ovf;
    ovf = 1'b0;
    for (int c = 0; c < 4; c++) begin
      if (fw_r[c] > 44'sd2147483647) begin
        pipe_data[32*c +: 32] = 32'h7fff_ffff;
        ovf = 1'b1;
      end else if (fw_r[c] < -44'sd2147483648) begin
        pipe_data[32*c +: 32] = 32'h8000_0000;
        ovf = 1'b1;
      end else begin
        pipe_data[32*c +: 32] = fw_r[c][DW-1:0];
      end
    end
    pipe_user = {fzd_r, ovf};
  end

  logic         o_vld_r;
  logic [127:0] o_data_r, sk_data_r;
  logic [1:0]   o_user_r, sk_user_r;
  logic         o_ld;

  assign o_ld = !o_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r    <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (o_ld) begin
      if (skid_vld_r) begin
        o_vld_r    <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        o_vld_r <= fvld_r;
      end
    end else if (en && fvld_r) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ld) begin
      o_data_r <= skid_vld_r ? sk_data_r : pipe_data;
      o_user_r <= skid_vld_r ? sk_user_r : pipe_user;
    end else if (!skid_vld_r) begin
      sk_data_r <= pipe_data;
      sk_user_r <= pipe_user;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = o_data_r;
  assign out_tuser  = o_user_r;

endmodule

// ===== rtl/core/qau_checker.sv =====
// Port-level checks for the quaternion arithmetic core, bound to quaternion_arith_unit_core.
module qau_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic [1:0]   out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_zdiv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tdata == '0 && !out_tuser[0])
    else $error("zero divisor result not clean");

  a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[31:0] == 32'h7fff_ffff || out_tdata[31:0] == 32'h8000_0000 ||
      out_tdata[63:32] == 32'h7fff_ffff || out_tdata[63:32] == 32'h8000_0000 ||
      out_tdata[95:64] == 32'h7fff_ffff || out_tdata[95:64] == 32'h8000_0000 ||
      out_tdata[127:96] == 32'h7fff_ffff || out_tdata[127:96] == 32'h8000_0000)
    else $error("overflow without a saturated component");

endmodule

bind quaternion_arith_unit_core qau_checker u_qau_checker (.*);
